// ===== src/rau_pkg.sv =====
// shared types and codes for the rational arithmetic unit
package rau_pkg;

  localparam int WIDTH_DEF = 32;

  localparam logic [2:0] OP_ADD  = 3'd0;
  localparam logic [2:0] OP_SUB  = 3'd1;
  localparam logic [2:0] OP_MUL  = 3'd2;
  localparam logic [2:0] OP_DIV  = 3'd3;
  localparam logic [2:0] OP_NEG  = 3'd4;
  localparam logic [2:0] OP_CMP  = 3'd5;
  localparam logic [2:0] OP_NORM = 3'd6;
  localparam logic [2:0] OP_RSVD = 3'd7;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_ZERO = 2'd1;
  localparam logic [1:0] ST_OVF  = 2'd2;
  localparam logic [1:0] ST_INV  = 2'd3;

  typedef struct packed {
    logic [2:0]         op;
    logic signed [31:0] a_num;
    logic signed [31:0] a_den;
    logic signed [31:0] b_num;
    logic signed [31:0] b_den;
  } in_word_t;

  typedef struct packed {
    logic signed [31:0] res_num;
    logic [30:0]        res_den;
    logic               is_equal;
    logic [1:0]         status;
  } out_word_t;

endpackage

// ===== src/rational_arithmetic_unit.sv =====
// rational arithmetic unit: fraction add, subtract, multiply, divide, negate, compare, normalize
// One word is taken at a time; in_ready is high only while the unit is idle, and a finished
// result waits in the output register so the next word can be accepted meanwhile. A word
// with a bad operand goes straight to the output; compare stops after the products. Other ops
// form products on the shared WIDTH x WIDTH multiplier, then run a binary gcd of subtract/shift
// steps on 2*WIDTH-bit magnitudes, then two restoring divisions through one shared divider.
module rational_arithmetic_unit #(
  parameter int WIDTH = rau_pkg::WIDTH_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  rau_pkg::in_word_t in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output rau_pkg::out_word_t out_data
);
  import rau_pkg::*;

  localparam int MW  = 2 * WIDTH;
  localparam int DCW = $clog2(MW);
  localparam logic [MW-1:0] LIM = {{(MW-1){1'b0}}, 1'b1} << (WIDTH - 1);

  typedef enum logic [2:0] {
    S_IDLE, S_MUL, S_FORM, S_GCD, S_DIV, S_CHECK, S_FIN
  } state_t;

  state_t state;
  logic [2:0] op;
  logic signed [WIDTH-1:0] an, ad, bn, bd;
  logic [1:0] mcnt;
  logic signed [MW-1:0] p0, p1, p2;
  logic [MW-1:0] u, v, sn, sd, qn, dq;
  logic [MW:0] rem;
  logic [DCW-1:0] dcnt;
  logic dsel, neg;
  logic signed [31:0] rnum;
  logic [30:0] rden;
  logic req;
  logic [1:0] rstat;

  logic signed [WIDTH-1:0] ian, iad, ibn, ibd, ma, mb;
  logic signed [MW-1:0] prod;
  logic signed [MW:0] n, d, nneg, dneg;
  logic [MW-1:0] mn, md, udiff, vdiff, qnext;
  logic [MW:0] rs;
  logic take, rbit, uses_b, ovf;
  logic [1:0] pre_stat;
  logic signed [WIDTH-1:0] rnw;
  logic [MW-1:0] rmag;

  assign in_ready = (state == S_IDLE);
  assign take = in_valid && in_ready;

  always_comb begin
    ian = in_data.a_num[WIDTH-1:0];
    iad = in_data.a_den[WIDTH-1:0];
    ibn = in_data.b_num[WIDTH-1:0];
    ibd = in_data.b_den[WIDTH-1:0];
    uses_b = (in_data.op <= OP_DIV) || (in_data.op == OP_CMP);
    pre_stat = ST_OK;
    if (in_data.op == OP_RSVD) begin
      pre_stat = ST_INV;
    end else if (in_data.op == OP_NORM) begin
      if (iad == '0) pre_stat = ST_ZERO;
    end else if (iad[WIDTH-1] || iad == '0 || (uses_b && (ibd[WIDTH-1] || ibd == '0))) begin
      pre_stat = ST_INV;
    end else if (in_data.op == OP_DIV && ibn == '0) begin
      pre_stat = ST_ZERO;
    end
  end

  always_comb begin
    case (mcnt)
      2'd0: begin
        ma = an;
        mb = (op == OP_MUL) ? bn : bd;
      end
      2'd1: begin
        ma = bn;
        mb = ad;
      end
      default: begin
        ma = ad;
        mb = (op == OP_DIV) ? bn : bd;
      end
    endcase
    prod = ma * mb;
  end

  always_comb begin
    case (op)
      OP_ADD: begin
        n = {p0[MW-1], p0} + {p1[MW-1], p1};
        d = {p2[MW-1], p2};
      end
      OP_SUB: begin
        n = {p0[MW-1], p0} - {p1[MW-1], p1};
        d = {p2[MW-1], p2};
      end
      OP_MUL, OP_DIV: begin
        n = {p0[MW-1], p0};
        d = {p2[MW-1], p2};
      end
      OP_NEG: begin
        n = -(MW+1)'(an);
        d = (MW+1)'(ad);
      end
      default: begin
        n = (MW+1)'(an);
        d = (MW+1)'(ad);
      end
    endcase
    nneg = -n;
    dneg = -d;
    mn = n[MW] ? nneg[MW-1:0] : n[MW-1:0];
    md = d[MW] ? dneg[MW-1:0] : d[MW-1:0];
    udiff = u - v;
    vdiff = v - u;
    rs = {rem[MW-1:0], dq[MW-1]};
    rbit = (rs >= {1'b0, v});
    qnext = {dq[MW-2:0], rbit};
    ovf = (dq > LIM - 1'b1) || (neg ? (qn > LIM) : (qn > LIM - 1'b1));
    rmag = neg ? -qn : qn;
    rnw = rmag[WIDTH-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready && state != S_FIN) out_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (take) begin
            op <= in_data.op;
            an <= ian;
            ad <= iad;
            bn <= ibn;
            bd <= ibd;
            mcnt <= 2'd0;
            rnum <= '0;
            rden <= '0;
            req <= 1'b0;
            rstat <= pre_stat;
            state <= (pre_stat == ST_OK) ? S_MUL : S_FIN;
          end
        end
        S_MUL: begin
          case (mcnt)
            2'd0: p0 <= prod;
            2'd1: p1 <= prod;
            default: p2 <= prod;
          endcase
          mcnt <= mcnt + 2'd1;
          if (mcnt == 2'd2) state <= S_FORM;
        end
        S_FORM: begin
          if (op == OP_CMP) begin
            req <= (p0 == p1);
            state <= S_FIN;
          end else begin
            u <= mn;
            v <= md;
            sn <= mn;
            sd <= md;
            neg <= (n[MW] != d[MW]) && (mn != '0);
            state <= S_GCD;
          end
        end
        S_GCD: begin
          if (u == '0) begin
            dq <= sn;
            rem <= '0;
            dcnt <= '0;
            dsel <= 1'b0;
            state <= S_DIV;
          end else if (!u[0] && !v[0]) begin
            u <= u >> 1;
            v <= v >> 1;
            sn <= sn >> 1;
            sd <= sd >> 1;
          end else if (!u[0]) begin
            u <= u >> 1;
          end else if (!v[0]) begin
            v <= v >> 1;
          end else if (u >= v) begin
            u <= udiff >> 1;
          end else begin
            v <= vdiff >> 1;
          end
        end
        S_DIV: begin
          if (dcnt == DCW'(MW - 1) && !dsel) begin
            qn <= qnext;
            dq <= sd;
            rem <= '0;
            dcnt <= '0;
            dsel <= 1'b1;
          end else begin
            rem <= rbit ? (rs - {1'b0, v}) : rs;
            dq <= qnext;
            dcnt <= dcnt + 1'b1;
            if (dcnt == DCW'(MW - 1)) state <= S_CHECK;
          end
        end
        S_CHECK: begin
          if (ovf) begin
            rstat <= ST_OVF;
          end else begin
            rnum <= 32'(rnw);
            rden <= 31'(dq[WIDTH-2:0]);
          end
          state <= S_FIN;
        end
        S_FIN: begin
          if (!out_valid || out_ready) begin
            out_data.res_num <= rnum;
            out_data.res_den <= rden;
            out_data.is_equal <= req;
            out_data.status <= rstat;
            out_valid <= 1'b1;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== src/rau_checker.sv =====
// port-level checks for the rational arithmetic unit, bound to the top level
module rau_checker (
  input logic               clk,
  input logic               rst,
  input logic               in_valid,
  input logic               in_ready,
  input rau_pkg::in_word_t  in_data,
  input logic               out_valid,
  input logic               out_ready,
  input rau_pkg::out_word_t out_data
);
  import rau_pkg::*;

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result word changed while stalled");

  a_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("accepted a word while busy");

  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.status != ST_OK |->
      out_data.res_num == '0 && out_data.res_den == '0 && !out_data.is_equal)
    else $error("error result carries data");

  a_eq_only_cmp: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.res_den != '0 |-> !out_data.is_equal)
    else $error("equal flag on an arithmetic result");

endmodule

bind rational_arithmetic_unit rau_checker u_rau_checker (.*);
